/* rtl/esdrp_pkg.sv */
// shared types, codes and constants of the display refresh pacer
package esdrp_pkg;

	localparam int TILES_WIDE_DEF  = 16;
	localparam int TILES_HIGH_DEF  = 8;
	localparam int CHUNK_TILES_DEF = 4;

	localparam int TIME_W   = 32;
	localparam int OP_W     = 2;
	localparam int CMD_W    = 2;
	localparam int TILE_X_W = 4;
	localparam int TILE_Y_W = 3;
	localparam int SHIFT_W  = 2;
	localparam int STEP_W   = 3;
	localparam int BURST_W  = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [TIME_W-1:0] NO_ITOW = '1;
	localparam logic [BURST_W-1:0] MAX_BURST = 6'd32;

	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
	localparam logic [OP_W-1:0] OP_SLEEP = 2'd2;

	localparam logic [CMD_W-1:0] CMD_RENDER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SLICE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FULL   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SAVE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_PANEL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REFRESH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST   = 3'd5;

	localparam logic [15:0] REFRESH_RST = 16'd1000;
	localparam logic [15:0] SLICE_RST   = 16'd10;
	localparam logic [31:0] SHIFT_RST   = 32'd60000;
	localparam logic [15:0] STALE_RST   = 16'd500;
	localparam logic [BURST_W-1:0] BURST_RST = 6'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAND,
		ST_TEST,
		ST_PLAN,
		ST_BURST,
		ST_RENDER,
		ST_FULL,
		ST_SAVE
	} state_t;

	typedef struct packed {
		logic             capture;
		logic             land;
		logic             test;
		logic             begin_upd;
		logic             sleep_upd;
		logic             render_upd;
		logic             slice_upd;
		logic             burst_load;
		logic             burst_one;
		logic             emit;
		logic [CMD_W-1:0] emit_cmd;
		logic             emit_last;
		logic             push;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            panel;
		logic            running;
		logic            busy;
		logic            landed;
		logic            flowing;
		logic            slice_due;
		logic            render_due;
		logic            out_free;
		logic            burst_zero;
		logic            burst_one_left;
		logic            slice_final;
	} dp_status_t;

	function automatic logic [SHIFT_W-1:0] shift_x_of(input logic [STEP_W-1:0] step);
		logic [SHIFT_W-1:0] r;
		case (step)
			3'd0: r = 2'd0;
			3'd1: r = 2'd1;
			3'd2: r = 2'd2;
			3'd3: r = 2'd2;
			3'd4: r = 2'd2;
			3'd5: r = 2'd1;
			3'd6: r = 2'd0;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [SHIFT_W-1:0] shift_y_of(input logic [STEP_W-1:0] step);
		logic [SHIFT_W-1:0] r;
		case (step)
			3'd0: r = 2'd0;
			3'd1: r = 2'd0;
			3'd2: r = 2'd0;
			3'd3: r = 2'd1;
			3'd4: r = 2'd2;
			3'd5: r = 2'd2;
			3'd6: r = 2'd2;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

endpackage

/* rtl/esdrp_ctrl.sv */
// sequencing state machine of the display refresh pacer
module esdrp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  esdrp_pkg::dp_status_t st,
	output esdrp_pkg::ctrl_cmd_t  cmd
);

	esdrp_pkg::state_t state_q, state_d;
	logic slice_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esdrp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign slice_last = st.burst_one_left | st.slice_final;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != esdrp_pkg::ST_IDLE);
		case (state_q)
			esdrp_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = esdrp_pkg::ST_LAND;
				end
			end
			esdrp_pkg::ST_LAND: begin
				state_d = esdrp_pkg::ST_IDLE;
				case (st.op)
					esdrp_pkg::OP_TICK: begin
						if (st.panel && st.running) begin
							cmd.land = 1'b1;
							state_d  = esdrp_pkg::ST_TEST;
						end
					end
					esdrp_pkg::OP_BEGIN: begin
						if (st.panel) begin
							cmd.begin_upd = 1'b1;
							state_d       = esdrp_pkg::ST_RENDER;
						end
					end
					esdrp_pkg::OP_SLEEP: begin
						if (st.panel && st.running) begin
							cmd.sleep_upd = 1'b1;
							state_d       = esdrp_pkg::ST_SAVE;
						end
					end
					default: state_d = esdrp_pkg::ST_IDLE;
				endcase
			end
			esdrp_pkg::ST_TEST: begin
				cmd.test = 1'b1;
				state_d  = esdrp_pkg::ST_PLAN;
			end
			esdrp_pkg::ST_PLAN: begin
				state_d = esdrp_pkg::ST_IDLE;
				if (st.busy) begin
					if (st.flowing) begin
						if (st.landed) begin
							cmd.slice_upd  = 1'b1;
							cmd.burst_load = 1'b1;
							state_d        = esdrp_pkg::ST_BURST;
						end
					end else if (st.slice_due) begin
						cmd.slice_upd  = 1'b1;
						cmd.burst_load = 1'b1;
						cmd.burst_one  = 1'b1;
						state_d        = esdrp_pkg::ST_BURST;
					end
				end else if (st.render_due && !(st.flowing && !st.landed)) begin
					cmd.render_upd = 1'b1;
					state_d        = esdrp_pkg::ST_RENDER;
				end
			end
			esdrp_pkg::ST_BURST: begin
				if (st.burst_zero || !st.busy) begin
					state_d = esdrp_pkg::ST_IDLE;
				end else if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_cmd  = esdrp_pkg::CMD_SLICE;
					cmd.emit_last = slice_last;
					cmd.push      = 1'b1;
					if (slice_last) begin
						state_d = esdrp_pkg::ST_IDLE;
					end
				end
			end
			esdrp_pkg::ST_RENDER: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_cmd  = esdrp_pkg::CMD_RENDER;
					cmd.emit_last = (st.op != esdrp_pkg::OP_BEGIN);
					state_d       = (st.op == esdrp_pkg::OP_BEGIN) ?
						esdrp_pkg::ST_FULL : esdrp_pkg::ST_IDLE;
				end
			end
			esdrp_pkg::ST_FULL: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_cmd  = esdrp_pkg::CMD_FULL;
					cmd.emit_last = 1'b1;
					state_d       = esdrp_pkg::ST_IDLE;
				end
			end
			esdrp_pkg::ST_SAVE: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_cmd  = esdrp_pkg::CMD_SAVE;
					cmd.emit_last = 1'b1;
					state_d       = esdrp_pkg::ST_IDLE;
				end
			end
			default: state_d = esdrp_pkg::ST_IDLE;
		endcase
	end

endmodule

/* rtl/esdrp_dp.sv */
// timers, epoch tracking, slice cursor, config registers and output beat register
module esdrp_dp #(
	parameter int TILES_WIDE  = esdrp_pkg::TILES_WIDE_DEF,
	parameter int TILES_HIGH  = esdrp_pkg::TILES_HIGH_DEF,
	parameter int CHUNK_TILES = esdrp_pkg::CHUNK_TILES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [esdrp_pkg::OP_W-1:0]          operation,
	input  logic [esdrp_pkg::TIME_W-1:0]        now_ms,
	input  logic                                epoch_valid,
	input  logic [esdrp_pkg::TIME_W-1:0]        epoch_itow,
	input  logic                                cfg_we,
	input  logic [esdrp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [esdrp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [esdrp_pkg::CMD_W-1:0]         command,
	output logic [esdrp_pkg::TILE_X_W-1:0]      tile_x,
	output logic [esdrp_pkg::TILE_Y_W-1:0]      tile_y,
	output logic [esdrp_pkg::SHIFT_W-1:0]       shift_x,
	output logic [esdrp_pkg::SHIFT_W-1:0]       shift_y,
	output logic                                last,
	input  esdrp_pkg::ctrl_cmd_t                cmd,
	output esdrp_pkg::dp_status_t               st
);

	localparam int ROW_CHUNKS = TILES_WIDE / CHUNK_TILES;
	localparam bit HAS_SLICES = (ROW_CHUNKS * TILES_HIGH) > 0;
	localparam int COL_W    = (ROW_CHUNKS > 1) ? $clog2(ROW_CHUNKS) : 1;
	localparam int ROW_W    = (TILES_HIGH > 1) ? $clog2(TILES_HIGH) : 1;
	localparam int COL_LAST = (ROW_CHUNKS > 0) ? ROW_CHUNKS - 1 : 0;
	localparam int ROW_LAST = TILES_HIGH - 1;
	localparam int TW       = esdrp_pkg::TIME_W;

	// latched input beat
	logic [esdrp_pkg::OP_W-1:0] op_q;
	logic [TW-1:0]              now_q;
	logic                       evalid_q;
	logic [TW-1:0]              itow_q;

	// config registers
	logic                             panel_q;
	logic [15:0]                      refresh_q;
	logic [15:0]                      slice_int_q;
	logic [31:0]                      shift_int_q;
	logic [15:0]                      stale_q;
	logic [esdrp_pkg::BURST_W-1:0]    spe_q;

	// block state
	logic                          running_q;
	logic                          busy_q;
	logic [TW-1:0]                 seen_itow_q;
	logic [TW-1:0]                 epoch_seen_q;
	logic [TW-1:0]                 render_time_q;
	logic [TW-1:0]                 shift_time_q;
	logic [TW-1:0]                 slice_time_q;
	logic [COL_W-1:0]              col_q;
	logic [ROW_W-1:0]              row_q;
	logic [esdrp_pkg::STEP_W-1:0]  step_q;
	logic [esdrp_pkg::BURST_W-1:0] remain_q;

	// decision flags
	logic landed_q;
	logic flowing_q;
	logic slice_due_q;
	logic render_due_q;
	logic shift_due_q;

	// output beat register
	logic                           out_valid_q;
	logic [esdrp_pkg::CMD_W-1:0]    command_q;
	logic [esdrp_pkg::TILE_X_W-1:0] tile_x_q;
	logic [esdrp_pkg::TILE_Y_W-1:0] tile_y_q;
	logic [esdrp_pkg::SHIFT_W-1:0]  shift_x_q;
	logic [esdrp_pkg::SHIFT_W-1:0]  shift_y_q;
	logic                           last_q;

	logic                           landed;
	logic                           col_end;
	logic                           row_end;
	logic                           out_free;
	logic [esdrp_pkg::BURST_W-1:0]  burst_len;
	logic [esdrp_pkg::TILE_X_W-1:0] slice_tx;
	logic [esdrp_pkg::TILE_Y_W-1:0] slice_ty;

	assign landed   = evalid_q && (itow_q != esdrp_pkg::NO_ITOW) && (itow_q != seen_itow_q);
	assign col_end  = (col_q == COL_W'(COL_LAST));
	assign row_end  = (row_q == ROW_W'(ROW_LAST));
	assign out_free = !out_valid_q || !out_stall;
	assign burst_len = (spe_q > esdrp_pkg::MAX_BURST) ? esdrp_pkg::MAX_BURST : spe_q;
	assign slice_tx = esdrp_pkg::TILE_X_W'(32'(col_q) * 32'(CHUNK_TILES));
	assign slice_ty = esdrp_pkg::TILE_Y_W'(row_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= operation;
			now_q    <= now_ms;
			evalid_q <= epoch_valid;
			itow_q   <= epoch_itow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_q     <= 1'b1;
			refresh_q   <= esdrp_pkg::REFRESH_RST;
			slice_int_q <= esdrp_pkg::SLICE_RST;
			shift_int_q <= esdrp_pkg::SHIFT_RST;
			stale_q     <= esdrp_pkg::STALE_RST;
			spe_q       <= esdrp_pkg::BURST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				esdrp_pkg::CFG_PANEL:   panel_q     <= cfg_data[0];
				esdrp_pkg::CFG_REFRESH: refresh_q   <= cfg_data[15:0];
				esdrp_pkg::CFG_SLICE:   slice_int_q <= cfg_data[15:0];
				esdrp_pkg::CFG_SHIFT:   shift_int_q <= cfg_data[31:0];
				esdrp_pkg::CFG_STALE:   stale_q     <= cfg_data[15:0];
				esdrp_pkg::CFG_BURST:   spe_q       <= cfg_data[esdrp_pkg::BURST_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			busy_q        <= 1'b0;
			seen_itow_q   <= esdrp_pkg::NO_ITOW;
			epoch_seen_q  <= '0;
			render_time_q <= '0;
			shift_time_q  <= '0;
			slice_time_q  <= '0;
			col_q         <= '0;
			row_q         <= '0;
			step_q        <= '0;
			remain_q      <= '0;
			landed_q      <= 1'b0;
			flowing_q     <= 1'b0;
			slice_due_q   <= 1'b0;
			render_due_q  <= 1'b0;
			shift_due_q   <= 1'b0;
		end else begin
			if (cmd.land) begin
				landed_q <= landed;
				if (landed) begin
					seen_itow_q  <= itow_q;
					epoch_seen_q <= now_q;
				end
			end
			if (cmd.test) begin
				flowing_q    <= (seen_itow_q != esdrp_pkg::NO_ITOW) &&
					((now_q - epoch_seen_q) < {16'd0, stale_q});
				slice_due_q  <= (now_q - slice_time_q) >= {16'd0, slice_int_q};
				render_due_q <= (now_q - render_time_q) >= {16'd0, refresh_q};
				shift_due_q  <= (now_q - shift_time_q) >= shift_int_q;
			end
			if (cmd.begin_upd) begin
				running_q     <= 1'b1;
				render_time_q <= now_q;
				shift_time_q  <= now_q;
			end
			if (cmd.sleep_upd) begin
				running_q <= 1'b0;
				busy_q    <= 1'b0;
				col_q     <= '0;
				row_q     <= '0;
			end
			if (cmd.render_upd) begin
				render_time_q <= now_q;
				slice_time_q  <= now_q;
				busy_q        <= HAS_SLICES;
				col_q         <= '0;
				row_q         <= '0;
				if (shift_due_q) begin
					shift_time_q <= now_q;
					step_q       <= step_q + 1'b1;
				end
			end
			if (cmd.slice_upd) begin
				slice_time_q <= now_q;
			end
			if (cmd.burst_load) begin
				remain_q <= cmd.burst_one ? esdrp_pkg::BURST_W'(1) : burst_len;
			end
			if (cmd.push) begin
				remain_q <= remain_q - 1'b1;
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q  <= '0;
						busy_q <= 1'b0;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			command_q <= cmd.emit_cmd;
			last_q    <= cmd.emit_last;
			tile_x_q  <= (cmd.emit_cmd == esdrp_pkg::CMD_SLICE) ? slice_tx : '0;
			tile_y_q  <= (cmd.emit_cmd == esdrp_pkg::CMD_SLICE) ? slice_ty : '0;
			shift_x_q <= (cmd.emit_cmd == esdrp_pkg::CMD_RENDER) ?
				esdrp_pkg::shift_x_of(step_q) : '0;
			shift_y_q <= (cmd.emit_cmd == esdrp_pkg::CMD_RENDER) ?
				esdrp_pkg::shift_y_of(step_q) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign command   = command_q;
	assign tile_x    = tile_x_q;
	assign tile_y    = tile_y_q;
	assign shift_x   = shift_x_q;
	assign shift_y   = shift_y_q;
	assign last      = last_q;

	always_comb begin
		st                = '0;
		st.op             = op_q;
		st.panel          = panel_q;
		st.running        = running_q;
		st.busy           = busy_q;
		st.landed         = landed_q;
		st.flowing        = flowing_q;
		st.slice_due      = slice_due_q;
		st.render_due     = render_due_q;
		st.out_free       = out_free;
		st.burst_zero     = (remain_q == '0);
		st.burst_one_left = (remain_q == esdrp_pkg::BURST_W'(1));
		st.slice_final    = col_end && row_end;
	end

endmodule

/* rtl/epoch_synced_display_refresh_pacer.sv */
// top level of the epoch synchronized display refresh pacer
// a begin or sleep passes the idle and land states before its first result beat is registered,
// a tick also the test and plan states; the input side stalls until the sequencer is idle again,
// so a new beat is taken only once the last is through; an ignored beat goes back from land
// a full 32 slice burst holds the input side, one slice beat per cycle unless out_stall holds it
// reset: arst_n clears all control state and loads config defaults, no clearing pass
module epoch_synced_display_refresh_pacer #(
	parameter int TILES_WIDE  = esdrp_pkg::TILES_WIDE_DEF,
	parameter int TILES_HIGH  = esdrp_pkg::TILES_HIGH_DEF,
	parameter int CHUNK_TILES = esdrp_pkg::CHUNK_TILES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [esdrp_pkg::OP_W-1:0]       operation,
	input  logic [esdrp_pkg::TIME_W-1:0]     now_ms,
	input  logic                             epoch_valid,
	input  logic [esdrp_pkg::TIME_W-1:0]     epoch_itow,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [esdrp_pkg::CMD_W-1:0]      command,
	output logic [esdrp_pkg::TILE_X_W-1:0]   tile_x,
	output logic [esdrp_pkg::TILE_Y_W-1:0]   tile_y,
	output logic [esdrp_pkg::SHIFT_W-1:0]    shift_x,
	output logic [esdrp_pkg::SHIFT_W-1:0]    shift_y,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [esdrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [esdrp_pkg::CFG_DATA_W-1:0] cfg_data
);

	esdrp_pkg::ctrl_cmd_t  cmd;
	esdrp_pkg::dp_status_t st;

	assign cfg_ready = 1'b1;

	esdrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	esdrp_dp #(
		.TILES_WIDE  (TILES_WIDE),
		.TILES_HIGH  (TILES_HIGH),
		.CHUNK_TILES (CHUNK_TILES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (operation),
		.now_ms      (now_ms),
		.epoch_valid (epoch_valid),
		.epoch_itow  (epoch_itow),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.command     (command),
		.tile_x      (tile_x),
		.tile_y      (tile_y),
		.shift_x     (shift_x),
		.shift_y     (shift_y),
		.last        (last),
		.cmd         (cmd),
		.st          (st)
	);

endmodule
